/* hw/rtl/nds_pkg.sv */
// ----------------------------------------------------------------------------
// nds_pkg
// Shared types and constants of the nearest-neighbor RGB565 downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nds_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_DIM    = 2'd2;

    // Register values after reset.
    localparam int SRC_WIDTH_RESET  = 320;
    localparam int SRC_HEIGHT_RESET = 240;
    localparam int MAX_DIM_RESET    = 400;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_DIV_W  = 7'b0000100,
        S_DIV_H  = 7'b0001000,
        S_DIV_QC = 7'b0010000,
        S_DIV_QR = 7'b0100000,
        S_RUN    = 7'b1000000
    } nds_state_t;

    // Which division the shared divider works on.
    typedef enum logic [1:0] {
        DIV_SEL_W  = 2'd0,
        DIV_SEL_H  = 2'd1,
        DIV_SEL_QC = 2'd2,
        DIV_SEL_QR = 2'd3
    } nds_div_sel_t;

    typedef struct packed {
        logic         prep;
        logic         div_start;
        logic         div_take;
        nds_div_sel_t div_sel;
        logic         pixel_accept;
    } nds_cmd_t;

    typedef struct packed {
        logic scale;
        logic div_done;
        logic frame_last;
        logic out_busy;
        logic cfg_hit;
    } nds_status_t;

endpackage

`default_nettype wire

/* hw/rtl/nds_divider.sv */
// ----------------------------------------------------------------------------
// nds_divider
// Restoring divider, one quotient bit per cycle, used during frame setup.
// ----------------------------------------------------------------------------
`default_nettype none

module nds_divider #(
    parameter int COORD_BITS = 12
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire [2*COORD_BITS-1:0]   dividend,
    input  wire [COORD_BITS-1:0]     divisor,
    output logic                     done,
    output logic [2*COORD_BITS-1:0]  quotient,
    output logic [COORD_BITS-1:0]    remainder
);

    localparam int DW    = 2 * COORD_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DW-1:0]         quo_reg, quo_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // No borrow means the shifted partial remainder covers the divisor.
            if (!diff[COORD_BITS]) begin
                rem_next = diff[COORD_BITS-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[COORD_BITS-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hw/rtl/nds_datapath.sv */
// ----------------------------------------------------------------------------
// nds_datapath
// Configuration registers, frame setup arithmetic, pick accumulators and the
// output register of the downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

module nds_datapath
    import nds_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_we,
    input  wire [1:0]               cfg_index,
    input  wire [COORD_BITS-1:0]    cfg_wdata,
    input  wire [7:0]               s_red,
    input  wire [7:0]               s_green,
    input  wire [7:0]               s_blue,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [15:0]             m_pixel_565,
    output logic [COORD_BITS-1:0]   m_dest_x,
    output logic [COORD_BITS-1:0]   m_dest_y,
    output logic [COORD_BITS-1:0]   m_dest_width,
    output logic [COORD_BITS-1:0]   m_dest_height,
    output logic                    m_frame_end,
    input  nds_cmd_t                cmd,
    output nds_status_t             status
);

    localparam int CB = COORD_BITS;

    localparam logic [CB-1:0] ONE     = CB'(1);
    localparam logic [CB-1:0] RST_W   = CB'(SRC_WIDTH_RESET);
    localparam logic [CB-1:0] RST_H   = CB'(SRC_HEIGHT_RESET);
    localparam logic [CB-1:0] RST_MAX = CB'(MAX_DIM_RESET);

    // Configuration.
    logic [CB-1:0] src_width_reg, src_height_reg, max_dim_reg;

    // Frame constants.
    logic [CB-1:0]   w_reg, h_reg, longer_reg;
    logic [2*CB-1:0] prod_w_reg, prod_h_reg;
    logic            scale_reg;
    logic [CB-1:0]   out_w_reg, out_h_reg;
    logic [CB-1:0]   qc_reg, rc_reg, qr_reg, rr_reg;

    // Raster and pick tracking.
    logic [CB-1:0] src_col_reg, src_col_next;
    logic [CB-1:0] src_row_reg, src_row_next;
    logic [CB-1:0] tgt_col_reg, tgt_col_next;
    logic [CB-1:0] tgt_row_reg, tgt_row_next;
    logic [CB-1:0] pick_col_reg, pick_col_next;
    logic [CB-1:0] rem_col_reg, rem_col_next;
    logic [CB-1:0] pick_row_reg, pick_row_next;
    logic [CB-1:0] rem_row_reg, rem_row_next;

    // Output word.
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   pix_reg;
    logic [CB-1:0] dx_reg, dy_reg, dwo_reg, dho_reg;
    logic          fend_reg;

    logic [CB-1:0]   eff_w, eff_h, eff_longer;
    logic [2*CB-1:0] div_dividend;
    logic [CB-1:0]   div_divisor;
    logic            div_done;
    logic [2*CB-1:0] div_quo;
    logic [CB-1:0]   div_rem;
    logic [CB-1:0]   div_q_clamped;

    logic          hit, col_end, row_end, row_pick;
    logic [CB:0]   col_sum, row_sum;
    logic          col_carry, row_carry;
    logic          last_x, last_y;

    assign eff_w      = (src_width_reg == '0) ? ONE : src_width_reg;
    assign eff_h      = (src_height_reg == '0) ? ONE : src_height_reg;
    assign eff_longer = (eff_w > eff_h) ? eff_w : eff_h;

    always_comb begin
        case (cmd.div_sel)
            DIV_SEL_W: begin
                div_dividend = prod_w_reg;
                div_divisor  = longer_reg;
            end
            DIV_SEL_H: begin
                div_dividend = prod_h_reg;
                div_divisor  = longer_reg;
            end
            DIV_SEL_QC: begin
                div_dividend = {{CB{1'b0}}, w_reg};
                div_divisor  = out_w_reg;
            end
            DIV_SEL_QR: begin
                div_dividend = {{CB{1'b0}}, h_reg};
                div_divisor  = out_h_reg;
            end
            default: begin
                div_dividend = prod_w_reg;
                div_divisor  = longer_reg;
            end
        endcase
    end

    nds_divider #(
        .COORD_BITS(COORD_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // A scaled side never drops below one pixel.
    assign div_q_clamped = (div_quo == '0) ? ONE : div_quo[CB-1:0];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= RST_W;
            src_height_reg <= RST_H;
            max_dim_reg    <= RST_MAX;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                CFG_MAX_DIM:    max_dim_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame setup.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 1'b0;
            out_w_reg <= ONE;
            out_h_reg <= ONE;
        end else if (cmd.prep) begin
            scale_reg <= (max_dim_reg != '0) && (eff_longer > max_dim_reg);
            out_w_reg <= eff_w;
            out_h_reg <= eff_h;
        end else if (cmd.div_take) begin
            case (cmd.div_sel)
                DIV_SEL_W: out_w_reg <= div_q_clamped;
                DIV_SEL_H: out_h_reg <= div_q_clamped;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            w_reg      <= eff_w;
            h_reg      <= eff_h;
            longer_reg <= eff_longer;
            prod_w_reg <= (2*CB)'(eff_w) * (2*CB)'(max_dim_reg);
            prod_h_reg <= (2*CB)'(eff_h) * (2*CB)'(max_dim_reg);
        end
        if (cmd.div_take) begin
            case (cmd.div_sel)
                DIV_SEL_QC: begin
                    qc_reg <= div_quo[CB-1:0];
                    rc_reg <= div_rem;
                end
                DIV_SEL_QR: begin
                    qr_reg <= div_quo[CB-1:0];
                    rr_reg <= div_rem;
                end
                default: ;
            endcase
        end
    end

    // Per-pixel tracking. Each pick step adds the precomputed quotient plus a
    // carry when the running remainder wraps past the destination size.
    always_comb begin
        hit = (src_row_reg == pick_row_reg) && (src_col_reg == pick_col_reg) &&
              (tgt_row_reg < out_h_reg) && (tgt_col_reg < out_w_reg);
        col_end  = ({1'b0, src_col_reg} + {{CB{1'b0}}, 1'b1}) >= {1'b0, w_reg};
        row_end  = ({1'b0, src_row_reg} + {{CB{1'b0}}, 1'b1}) >= {1'b0, h_reg};
        row_pick = (src_row_reg == pick_row_reg) && (tgt_row_reg < out_h_reg);

        col_sum   = {1'b0, rem_col_reg} + {1'b0, rc_reg};
        col_carry = col_sum >= {1'b0, out_w_reg};
        row_sum   = {1'b0, rem_row_reg} + {1'b0, rr_reg};
        row_carry = row_sum >= {1'b0, out_h_reg};

        last_x = ({1'b0, tgt_col_reg} + {{CB{1'b0}}, 1'b1}) == {1'b0, out_w_reg};
        last_y = ({1'b0, tgt_row_reg} + {{CB{1'b0}}, 1'b1}) == {1'b0, out_h_reg};

        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        tgt_col_next  = tgt_col_reg;
        tgt_row_next  = tgt_row_reg;
        pick_col_next = pick_col_reg;
        rem_col_next  = rem_col_reg;
        pick_row_next = pick_row_reg;
        rem_row_next  = rem_row_reg;

        if (cmd.prep) begin
            src_col_next  = '0;
            src_row_next  = '0;
            tgt_col_next  = '0;
            tgt_row_next  = '0;
            pick_col_next = '0;
            rem_col_next  = '0;
            pick_row_next = '0;
            rem_row_next  = '0;
        end else if (cmd.pixel_accept) begin
            if (hit) begin
                tgt_col_next  = tgt_col_reg + ONE;
                pick_col_next = pick_col_reg + qc_reg + {{(CB-1){1'b0}}, col_carry};
                rem_col_next  = col_carry ? (col_sum[CB-1:0] - out_w_reg)
                                          : col_sum[CB-1:0];
            end
            if (col_end) begin
                src_col_next  = '0;
                tgt_col_next  = '0;
                pick_col_next = '0;
                rem_col_next  = '0;
                if (row_pick) begin
                    tgt_row_next  = tgt_row_reg + ONE;
                    pick_row_next = pick_row_reg + qr_reg +
                                    {{(CB-1){1'b0}}, row_carry};
                    rem_row_next  = row_carry ? (row_sum[CB-1:0] - out_h_reg)
                                              : row_sum[CB-1:0];
                end
                if (!row_end) begin
                    src_row_next = src_row_reg + ONE;
                end
            end else begin
                src_col_next = src_col_reg + ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            tgt_col_reg  <= '0;
            tgt_row_reg  <= '0;
            pick_col_reg <= '0;
            rem_col_reg  <= '0;
            pick_row_reg <= '0;
            rem_row_reg  <= '0;
        end else begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            tgt_col_reg  <= tgt_col_next;
            tgt_row_reg  <= tgt_row_next;
            pick_col_reg <= pick_col_next;
            rem_col_reg  <= rem_col_next;
            pick_row_reg <= pick_row_next;
            rem_row_reg  <= rem_row_next;
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.pixel_accept && hit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.pixel_accept && hit) begin
            pix_reg  <= {s_red[7:3], s_green[7:2], s_blue[7:3]};
            dx_reg   <= tgt_col_reg;
            dy_reg   <= tgt_row_reg;
            dwo_reg  <= out_w_reg;
            dho_reg  <= out_h_reg;
            fend_reg <= last_x && last_y;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_565   = pix_reg;
    assign m_dest_x      = dx_reg;
    assign m_dest_y      = dy_reg;
    assign m_dest_width  = dwo_reg;
    assign m_dest_height = dho_reg;
    assign m_frame_end   = fend_reg;

    always_comb begin
        status.scale      = scale_reg;
        status.div_done   = div_done;
        status.frame_last = col_end && row_end;
        status.out_busy   = m_valid_reg && !m_ready;
        status.cfg_hit    = cfg_we &&
                            (cfg_index inside {CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_MAX_DIM});
    end

endmodule

`default_nettype wire

/* hw/rtl/nds_ctrl.sv */
// ----------------------------------------------------------------------------
// nds_ctrl
// Sequencer of the downscaler: frame setup through the shared divider, then
// the pixel run that ends with the last source pixel or a register write.
// ----------------------------------------------------------------------------
`default_nettype none

module nds_ctrl
    import nds_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  nds_status_t  status,
    output nds_cmd_t     cmd
);

    nds_state_t state_reg, state_next;
    logic       launched_reg, launched_next;

    always_comb begin
        state_next       = state_reg;
        launched_next    = launched_reg;
        cmd.prep         = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.div_take     = 1'b0;
        cmd.pixel_accept = 1'b0;
        s_ready          = 1'b0;

        case (state_reg)
            S_DIV_H:  cmd.div_sel = DIV_SEL_H;
            S_DIV_QC: cmd.div_sel = DIV_SEL_QC;
            S_DIV_QR: cmd.div_sel = DIV_SEL_QR;
            default:  cmd.div_sel = DIV_SEL_W;
        endcase

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_DIV_W;
            end
            S_DIV_W, S_DIV_H, S_DIV_QC, S_DIV_QR: begin
                if ((state_reg == S_DIV_W) && !status.scale) begin
                    // Source size is kept, only the pick steps are needed.
                    state_next = S_DIV_QC;
                end else if (!launched_reg) begin
                    cmd.div_start = 1'b1;
                    launched_next = 1'b1;
                end else if (status.div_done) begin
                    cmd.div_take  = 1'b1;
                    launched_next = 1'b0;
                    case (state_reg)
                        S_DIV_W:  state_next = S_DIV_H;
                        S_DIV_H:  state_next = S_DIV_QC;
                        S_DIV_QC: state_next = S_DIV_QR;
                        default:  state_next = S_RUN;
                    endcase
                end
            end
            S_RUN: begin
                s_ready          = !status.out_busy;
                cmd.pixel_accept = s_valid && !status.out_busy;
                if (cmd.pixel_accept && status.frame_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next    = S_IDLE;
                launched_next = 1'b0;
            end
        endcase

        // A register write ends the frame; the next word starts a new one.
        if (status.cfg_hit) begin
            state_next    = S_IDLE;
            launched_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/nearest_downscale_rgb565_core.sv */
// ----------------------------------------------------------------------------
// nearest_downscale_rgb565_core
// Nearest-neighbor downscaler, RGB888 source words in, RGB565 words out.
// ----------------------------------------------------------------------------
// Frame setup runs on the first word of a frame, through the bit-serial divider:
// width and height quotients when downscaling, then the two pick-step quotients.
// After setup one source word per cycle is taken while the output is free;
// a picked word appears on the output register in the cycle after acceptance.
// Synchronous active-low reset restores register defaults and ends any frame;
// no clearing pass is needed.
`default_nettype none

module nearest_downscale_rgb565_core
    import nds_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_we,
    input  wire [1:0]               cfg_index,
    input  wire [COORD_BITS-1:0]    cfg_wdata,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire [7:0]               s_red,
    input  wire [7:0]               s_green,
    input  wire [7:0]               s_blue,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [15:0]             m_pixel_565,
    output logic [COORD_BITS-1:0]   m_dest_x,
    output logic [COORD_BITS-1:0]   m_dest_y,
    output logic [COORD_BITS-1:0]   m_dest_width,
    output logic [COORD_BITS-1:0]   m_dest_height,
    output logic                    m_frame_end
);

    nds_cmd_t    cmd;
    nds_status_t status;

    nds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nds_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_565   (m_pixel_565),
        .m_dest_x      (m_dest_x),
        .m_dest_y      (m_dest_y),
        .m_dest_width  (m_dest_width),
        .m_dest_height (m_dest_height),
        .m_frame_end   (m_frame_end),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

/* sim/tb_nearest_downscale_rgb565_core.sv */
// ----------------------------------------------------------------------------
// tb_nearest_downscale_rgb565_core
// Self-checking bench for the nearest-neighbor RGB565 downscaler. Source words
// are streamed in bursts under a range of frame sizes and size limits, and
// every output word is compared against a cycle-free model of the pick logic.
// ----------------------------------------------------------------------------

module tb_nearest_downscale_rgb565_core;
    import nds_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int SETUP_CYCLES = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_WORDS = 1800;
    localparam int PROBE_ROWS   = 10;

    // The index port is two bits wide, so the fourth index is reachable.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] pixel;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic        last;
    } pick_t;

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        typed;
        logic [15:0] pix;
    } probe_t;

    typedef enum logic [1:0] {
        REGS_KEEP,
        REGS_ALL,
        REGS_SPARE
    } regs_plan_t;

    // Words sent right after reset, under the default 320x240 frame with no
    // downscale, so every word is picked in column order on row zero.
    localparam probe_t PROBES [PROBE_ROWS] = '{
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF},
        '{8'h00, 8'h00, 8'h00, 1'b1, 16'h0000},
        '{8'hF8, 8'hFC, 8'hF8, 1'b1, 16'hFFFF},
        '{8'h07, 8'h03, 8'h07, 1'b1, 16'h0000},
        '{8'hF8, 8'h00, 8'h00, 1'b1, 16'hF800},
        '{8'h00, 8'hFC, 8'h00, 1'b1, 16'h07E0},
        '{8'h00, 8'h00, 8'hF8, 1'b1, 16'h001F},
        '{8'h80, 8'h40, 8'h20, 1'b0, 16'h0000},
        '{8'h12, 8'h34, 8'h56, 1'b0, 16'h0000},
        '{8'hA5, 8'h5A, 8'hC3, 1'b0, 16'h0000}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_SRC_WIDTH;
    logic [11:0] cfg_wdata = 12'd0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_red     = 8'd0;
    logic [7:0]  s_green   = 8'd0;
    logic [7:0]  s_blue    = 8'd0;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_pixel_565;
    logic [11:0] m_dest_x;
    logic [11:0] m_dest_y;
    logic [11:0] m_dest_width;
    logic [11:0] m_dest_height;
    logic        m_frame_end;

    nearest_downscale_rgb565_core #(
        .COORD_BITS(12)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_565  (m_pixel_565),
        .m_dest_x     (m_dest_x),
        .m_dest_y     (m_dest_y),
        .m_dest_width (m_dest_width),
        .m_dest_height(m_dest_height),
        .m_frame_end  (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // Shadow copy of the registers and of the frame walk.
    logic [11:0] reg_w = 12'(SRC_WIDTH_RESET);
    logic [11:0] reg_h = 12'(SRC_HEIGHT_RESET);
    logic [11:0] reg_m = 12'(MAX_DIM_RESET);
    logic [11:0] col_src = '0, row_src = '0, col_dst = '0, row_dst = '0;
    logic [11:0] col_pick = '0, col_rem = '0, row_pick = '0, row_rem = '0;
    logic [11:0] size_w = 12'd1, size_h = 12'd1;
    bit          in_frame = 1'b0;

    pick_t       due_picks [$];
    int unsigned fail_count  = 0;
    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    bit          hold_req    = 1'b0;

    // Walks one source word through the frame and returns whether it is picked.
    function automatic bit downscale_word(input logic [7:0] r, g, b, output pick_t res);
        int unsigned w, h, longer, dw, dh, sum;
        bit hit;
        w = (reg_w == 0) ? 1 : 32'(reg_w);
        h = (reg_h == 0) ? 1 : 32'(reg_h);
        if (!in_frame) begin
            longer = (w > h) ? w : h;
            dw = w;
            dh = h;
            if (reg_m != 0 && longer > reg_m) begin
                dw = (w * reg_m) / longer;
                dh = (h * reg_m) / longer;
                if (dw < 1) dw = 1;
                if (dh < 1) dh = 1;
            end
            size_w = 12'(dw);
            size_h = 12'(dh);
            col_src = '0; row_src = '0; col_dst = '0; row_dst = '0;
            col_pick = '0; col_rem = '0; row_pick = '0; row_rem = '0;
            in_frame = 1'b1;
        end
        dw = 32'(size_w);
        dh = 32'(size_h);
        res = '0;
        hit = (row_src == row_pick) && (col_src == col_pick) && (row_dst < dh) && (col_dst < dw);
        if (hit) begin
            res.pixel = {r[7:3], g[7:2], b[7:3]};
            res.x     = col_dst;
            res.y     = row_dst;
            res.w     = size_w;
            res.h     = size_h;
            res.last  = (col_dst + 1 == dw) && (row_dst + 1 == dh);
            col_dst   = col_dst + 12'd1;
            sum       = col_rem + w;
            col_pick  = col_pick + 12'(sum / dw);
            col_rem   = 12'(sum % dw);
        end
        if (col_src + 1 >= w) begin
            col_src  = '0;
            col_dst  = '0;
            col_pick = '0;
            col_rem  = '0;
            if (row_src == row_pick && row_dst < dh) begin
                row_dst  = row_dst + 12'd1;
                sum      = row_rem + h;
                row_pick = row_pick + 12'(sum / dh);
                row_rem  = 12'(sum % dh);
            end
            if (row_src + 1 >= h) in_frame = 1'b0;
            else row_src = row_src + 12'd1;
        end else begin
            col_src = col_src + 12'd1;
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        pick_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_picks.size() == 0) begin
                $error("unexpected word: pixel_565 %h at (%0d,%0d)",
                       m_pixel_565, m_dest_x, m_dest_y);
                fail_count++;
            end else begin
                want = due_picks.pop_front();
                check_field("pixel_565", 32'(want.pixel), 32'(m_pixel_565));
                check_field("dest_x", 32'(want.x), 32'(m_dest_x));
                check_field("dest_y", 32'(want.y), 32'(m_dest_y));
                check_field("dest_width", 32'(want.w), 32'(m_dest_width));
                check_field("dest_height", 32'(want.h), 32'(m_dest_height));
                check_field("frame_end", 32'(want.last), 32'(m_frame_end));
            end
        end
    end

    // Receiver: randomly chosen stretches of steady acceptance or random stalls,
    // plus one long hold-off so the pipeline backs up into the input.
    initial begin : receiver
        int unsigned span;
        bit held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            span = $urandom_range(4, 40);
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b1;
                repeat (span) @(posedge aclk);
            end else begin
                repeat (span) begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic push_word(input logic [7:0] r, g, b, input bit typed, input pick_t typed_res);
        int unsigned gap;
        pick_t res;
        bit hit;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        words_sent++;
        hit = downscale_word(r, g, b, res);
        if (typed) due_picks.push_back(typed_res);
        else if (hit) due_picks.push_back(res);
    endtask

    // A frame's first word may still be in setup after the last output word,
    // so give the divider time to finish before touching the registers.
    task automatic settle_block();
        s_valid <= 1'b0;
        burst_left = 0;
        while (due_picks.size() != 0) @(posedge aclk);
        repeat (SETUP_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_SRC_WIDTH:  reg_w = val;
            CFG_SRC_HEIGHT: reg_h = val;
            CFG_MAX_DIM:    reg_m = val;
            default: ;
        endcase
        if (idx != CFG_SPARE) in_frame = 1'b0;
    endtask

    task automatic run_phase(input regs_plan_t plan, input logic [11:0] w, h, m,
                             input int unsigned count);
        if (plan != REGS_KEEP) begin
            settle_block();
            if (plan == REGS_ALL) begin
                write_reg(CFG_SRC_WIDTH, w);
                write_reg(CFG_SRC_HEIGHT, h);
                write_reg(CFG_MAX_DIM, m);
            end
            if (plan == REGS_SPARE || $urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, 12'($urandom));
            cfg_we <= 1'b0;
        end
        repeat (count) push_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    initial begin : stimulus
        int unsigned fw, fh, mx, area, count;
        regs_plan_t plan;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PROBE_ROWS; i++)
            push_word(PROBES[i].r, PROBES[i].g, PROBES[i].b, PROBES[i].typed,
                      pick_t'{PROBES[i].pix, 12'(i), 12'd0, 12'd320, 12'd240, 1'b0});

        run_phase(REGS_ALL, 12'd4, 12'd3, 12'd0, 24);
        run_phase(REGS_ALL, 12'd7, 12'd5, 12'd3, 70);
        run_phase(REGS_KEEP, 12'd0, 12'd0, 12'd0, 10);
        // A write to the spare index must not break the frame in progress.
        run_phase(REGS_SPARE, 12'd0, 12'd0, 12'd0, 25);
        run_phase(REGS_ALL, 12'd0, 12'd0, 12'd5, 4);
        run_phase(REGS_ALL, 12'd1, 12'd1, 12'd0, 3);
        run_phase(REGS_ALL, 12'd4095, 12'd4095, 12'd4095, 20);
        run_phase(REGS_ALL, 12'd4095, 12'd2, 12'd1, 20);
        run_phase(REGS_ALL, 12'd1, 12'd4095, 12'd1, 20);
        run_phase(REGS_ALL, 12'd16, 12'd4, 12'd4, 64);
        // The long hold-off starts only once words are flowing again.
        run_phase(REGS_ALL, 12'd8, 12'd8, 12'd0, 0);
        hold_req = 1'b1;
        run_phase(REGS_KEEP, 12'd0, 12'd0, 12'd0, 192);

        while (words_sent < TARGET_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1:    plan = REGS_KEEP;
                2:       plan = REGS_SPARE;
                default: plan = REGS_ALL;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                fw = $urandom_range(1, 200);
                fh = $urandom_range(1, 3);
                mx = $urandom_range(0, 250);
            end else begin
                fw = $urandom_range(1, 12);
                fh = $urandom_range(1, 10);
                mx = $urandom_range(0, 14);
            end
            if ($urandom_range(0, 19) == 0) fw = 0;
            if ($urandom_range(0, 19) == 0) fh = 0;
            if (plan == REGS_ALL) begin
                area  = ((fw == 0) ? 1 : fw) * ((fh == 0) ? 1 : fh);
                count = area * $urandom_range(0, 3) + $urandom_range(0, area - 1);
                if (count == 0) count = 1;
                if (count > 650) count = 650;
            end else begin
                count = $urandom_range(1, 40);
            end
            if (count > TARGET_WORDS - words_sent) count = TARGET_WORDS - words_sent;
            run_phase(plan, 12'(fw), 12'(fh), 12'(mx), count);
        end

        settle_block();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
